FILE: rtl/band_okvs_decoder_top_macros.svh
// Assertion macros used by the band decoder top file.
`ifndef BAND_OKVS_DECODER_TOP_MACROS_SVH
`define BAND_OKVS_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define BOD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define BOD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bod_pkg.sv
package bod_pkg;

  localparam int unsigned SLOTS_DEF     = 4096;
  localparam int unsigned BAND_BITS_DEF = 128;
  localparam int unsigned SPAN_W        = 12;
  localparam int unsigned SLOT_W        = 12;
  localparam int unsigned DIV_W         = 64;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 12'd3968;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       data_lo;
    logic [63:0]       data_hi;
    logic [63:0]       band_lo;
    logic [63:0]       band_hi;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value_lo;
    logic [63:0] value_hi;
  } out_item_t;

  // Queue side of the link between the front and the back.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

  typedef struct packed {
    logic idle;
    logic ram_we;
    logic pop;
  } back_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MOD,
    BK_SWEEP,
    BK_DRAIN,
    BK_FIN
  } back_state_t;

endpackage

FILE: rtl/band_okvs_decoder_top.sv
// Band decoder: a table of SLOTS slots of 128 bits. A write request stores one slot
// while the back end stays idle. A query request divides band_lo by span with a
// restoring divider at one bit per cycle, rounds the remainder down to a multiple
// of 8 as the start slot, then reads BAND_BITS slots from the single port slot
// memory one per cycle and XORs those whose band bit is set. A query holds the back
// end while it is taken from the queue, divided, read over BAND_BITS slots, the
// last read folded in and the result loaded into the result register, which waits
// until any earlier result has been taken. A two-entry queue in front lets new
// requests be taken while a query runs, and the result sits in an output register
// until it is taken. Slots that were never written hold unknown data. Write span
// only while the block is idle.
`include "band_okvs_decoder_top_macros.svh"

module band_okvs_decoder_top #(
  parameter int unsigned SLOTS     = bod_pkg::SLOTS_DEF,
  parameter int unsigned BAND_BITS = bod_pkg::BAND_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bod_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bod_pkg::out_item_t         out_item,
  input  logic                       cfg_we,
  input  logic [bod_pkg::SPAN_W-1:0] cfg_data
);

  // The span register is the modulus that places each query in the table.
  logic [bod_pkg::SPAN_W-1:0] span_r, span_nxt;

  bod_pkg::queue_head_t  head;
  bod_pkg::back_status_t status;
  logic                  query_pop;

  assign span_nxt  = cfg_we ? cfg_data : span_r;
  assign query_pop = status.pop && (head.item.op == bod_pkg::OP_QUERY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= bod_pkg::SPAN_RESET;
    end else begin
      span_r <= span_nxt;
    end
  end

  // The front end only buffers requests; all decoding happens in the back end.
  bod_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item (in_item),
    .head    (head),
    .pop     (status.pop)
  );

  bod_back #(
    .SLOTS    (SLOTS),
    .BAND_BITS(BAND_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .span     (span_r),
    .head     (head),
    .status   (status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  `BOD_ASSERT_NOW(a_pop_nonempty, status.pop, head.valid, "pop from empty queue")
  `BOD_ASSERT_NOW(a_we_idle, status.ram_we, status.idle, "slot write outside idle")
  `BOD_ASSERT_NEXT(a_query_busy, query_pop, !status.idle, "query did not start")

endmodule

FILE: rtl/bod_ram.sv
module bod_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bod_front.sv
module bod_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bod_pkg::in_item_t    in_item,
  output bod_pkg::queue_head_t head,
  input  logic                 pop
);

  // Two-entry queue that lets the input side run ahead of a long query.
  bod_pkg::in_item_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_item;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = ent_r[rd_ptr_r];

endmodule

FILE: rtl/bod_back.sv
module bod_back #(
  parameter int unsigned SLOTS     = bod_pkg::SLOTS_DEF,
  parameter int unsigned BAND_BITS = bod_pkg::BAND_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bod_pkg::SPAN_W-1:0]  span,
  input  bod_pkg::queue_head_t        head,
  output bod_pkg::back_status_t       status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bod_pkg::out_item_t          out_item
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned JW = $clog2(BAND_BITS);
  localparam int unsigned CW = $clog2(bod_pkg::DIV_W);
  localparam logic [JW-1:0] J_LAST = JW'(BAND_BITS - 1);
  localparam logic [CW-1:0] C_LAST = CW'(bod_pkg::DIV_W - 1);

  bod_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [JW-1:0]                j_r, j_nxt;
  logic [bod_pkg::SPAN_W-1:0]   span_r, span_nxt;
  logic [bod_pkg::SPAN_W-1:0]   rem_r, rem_nxt;
  logic [bod_pkg::DIV_W-1:0]    div_r, div_nxt;
  logic [127:0]                 band_r, band_nxt;
  logic [127:0]                 acc_r, acc_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic                         rd_bit_r, rd_bit_nxt;
  logic                         ov_r, ov_nxt;
  bod_pkg::out_item_t           out_r, out_nxt;

  logic                         pop;
  logic                         ram_we;
  logic [AW-1:0]                ram_addr;
  logic [127:0]                 ram_rdata;
  logic [bod_pkg::SPAN_W:0]     trial;
  logic [bod_pkg::SPAN_W:0]     sum;
  logic [31:0]                  slot32;
  logic [31:0]                  sum32;

  assign pop    = (state_r == bod_pkg::BK_IDLE) && head.valid;
  assign ram_we = pop && (head.item.op == bod_pkg::OP_WRITE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bod_pkg::BK_IDLE: begin
        if (pop && head.item.op == bod_pkg::OP_QUERY) begin
          state_nxt = bod_pkg::BK_MOD;
        end
      end
      bod_pkg::BK_MOD: begin
        if (cnt_r == C_LAST) begin
          state_nxt = bod_pkg::BK_SWEEP;
        end
      end
      bod_pkg::BK_SWEEP: begin
        if (j_r == J_LAST) begin
          state_nxt = bod_pkg::BK_DRAIN;
        end
      end
      bod_pkg::BK_DRAIN: state_nxt = bod_pkg::BK_FIN;
      bod_pkg::BK_FIN: begin
        if (!ov_r || out_ready) begin
          state_nxt = bod_pkg::BK_IDLE;
        end
      end
      default: state_nxt = bod_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_nxt    = cnt_r;
    j_nxt      = j_r;
    span_nxt   = span_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    band_nxt   = band_r;
    acc_nxt    = acc_r;
    rd_vld_nxt = 1'b0;
    rd_bit_nxt = 1'b0;
    ov_nxt     = ov_r && !out_ready;
    out_nxt    = out_r;
    trial      = {rem_r, div_r[bod_pkg::DIV_W-1]};
    sum        = {1'b0, rem_r} + (bod_pkg::SPAN_W+1)'(j_r);
    sum32      = 32'(sum);
    slot32     = 32'(head.item.slot);
    ram_addr   = sum32[AW-1:0];

    if (rd_vld_r && rd_bit_r) begin
      acc_nxt = acc_r ^ ram_rdata;
    end

    unique case (state_r)
      bod_pkg::BK_IDLE: begin
        ram_addr = slot32[AW-1:0];
        if (pop && head.item.op == bod_pkg::OP_QUERY) begin
          cnt_nxt  = '0;
          j_nxt    = '0;
          span_nxt = span;
          rem_nxt  = '0;
          div_nxt  = head.item.band_lo;
          band_nxt = {head.item.band_hi, head.item.band_lo};
          acc_nxt  = '0;
        end
      end
      bod_pkg::BK_MOD: begin
        // One quotient bit per cycle of a restoring division.
        if (trial >= {1'b0, span_r}) begin
          trial = trial - {1'b0, span_r};
        end
        rem_nxt = trial[bod_pkg::SPAN_W-1:0];
        div_nxt = {div_r[bod_pkg::DIV_W-2:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == C_LAST) begin
          if (span_r == '0) begin
            rem_nxt = '0;
          end else begin
            rem_nxt = {trial[bod_pkg::SPAN_W-1:3], 3'b000};
          end
        end
      end
      bod_pkg::BK_SWEEP: begin
        // rem_r now holds the start slot; read one band position a cycle.
        rd_vld_nxt = 1'b1;
        rd_bit_nxt = band_r[j_r];
        j_nxt      = j_r + JW'(1);
      end
      bod_pkg::BK_DRAIN: begin
      end
      bod_pkg::BK_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt  = 1'b1;
          out_nxt = '{value_lo: acc_r[63:0], value_hi: acc_r[127:64]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bod_pkg::BK_IDLE;
      ov_r     <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    j_r      <= j_nxt;
    span_r   <= span_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    band_r   <= band_nxt;
    acc_r    <= acc_nxt;
    rd_bit_r <= rd_bit_nxt;
    out_r    <= out_nxt;
  end

  bod_ram #(
    .WIDTH(128),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata({head.item.data_hi, head.item.data_lo}),
    .rdata(ram_rdata)
  );

  assign status.idle   = (state_r == bod_pkg::BK_IDLE);
  assign status.ram_we = ram_we;
  assign status.pop    = pop;
  assign out_valid     = ov_r;
  assign out_item      = out_r;

endmodule

FILE: sim/tb_band_okvs_decoder_top.sv
`timescale 1ns / 100ps

module tb_band_okvs_decoder_top;

  // A query holds the back end much longer than a write does.
  localparam int QUERY_CYCLES = 200;
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bod_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bod_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [bod_pkg::SPAN_W-1:0] cfg_data = '0;

  band_okvs_decoder_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: our own copy of the slot table, a record of which slots
  // were ever written, and the span register.
  logic [127:0] slot_mirror [bod_pkg::SLOTS_DEF];
  bit slot_written [bod_pkg::SLOTS_DEF];
  logic [bod_pkg::SPAN_W-1:0] span_shadow;

  bod_pkg::in_item_t pending_requests[$];
  bod_pkg::out_item_t expected_values[$];
  int fail_count = 0;
  int cycle_count = 0;

  // Controls set by the stimulus process, and the hold-off counter kept by the monitor.
  bit sender_paused = 1'b0;
  bit hold_receiver = 1'b0;
  int hold_cycles = 0;

  function automatic logic [11:0] start_slot(logic [63:0] row_lo);
    logic [63:0] rem;
    if (span_shadow == 0) return 12'd0;
    rem = row_lo % {52'd0, span_shadow};
    return rem[11:0] & 12'hff8;
  endfunction

  // Applies one request to the mirror at the point of acceptance and queues
  // the decoded XOR for a query.
  function automatic void predict_request(bod_pkg::in_item_t req);
    logic [127:0] acc;
    logic [127:0] band;
    logic [11:0] base;
    logic [11:0] addr;
    if (req.op == bod_pkg::OP_WRITE) begin
      slot_mirror[req.slot] = {req.data_hi, req.data_lo};
      slot_written[req.slot] = 1'b1;
    end else begin
      acc = '0;
      band = {req.band_hi, req.band_lo};
      base = start_slot(req.band_lo);
      for (int j = 0; j < bod_pkg::BAND_BITS_DEF; j++) begin
        addr = base + j[11:0];
        if (band[j]) acc ^= slot_mirror[addr];
      end
      expected_values.push_back('{value_lo: acc[63:0], value_hi: acc[127:64]});
    end
  endfunction

  // Random band whose set bits in the upper half only touch written slots under the current span.
  function automatic bod_pkg::in_item_t make_query(logic [63:0] row_lo,
                                                   logic [63:0] row_hi);
    bod_pkg::in_item_t q;
    logic [11:0] base;
    logic [127:0] band;
    logic [11:0] addr;
    q = '0;
    q.op = bod_pkg::OP_QUERY;
    q.slot = 12'($urandom);
    q.data_lo = {$urandom, $urandom};
    q.data_hi = {$urandom, $urandom};
    band = {row_hi, row_lo};
    base = start_slot(row_lo);
    // band_lo feeds the start position, so only bits that were not
    // needed for it are cleared; bits 0..63 stay as given.
    for (int j = 64; j < 128; j++) begin
      addr = base + j[11:0];
      if (!slot_written[addr]) band[j] = 1'b0;
    end
    q.band_lo = band[63:0];
    q.band_hi = band[127:64];
    return q;
  endfunction

  function automatic bit low_half_safe(logic [63:0] row_lo);
    logic [11:0] base;
    logic [11:0] addr;
    base = start_slot(row_lo);
    for (int j = 0; j < 64; j++) begin
      addr = base + j[11:0];
      if (row_lo[j] && !slot_written[addr]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Row whose remainder under the current span lands the start either in
  // slots 0..128 or, for a span above 3840, at 3840 or later, so the whole
  // band stays inside the filled block that wraps around slot 0.
  function automatic logic [63:0] pick_row();
    logic [63:0] q;
    logic [63:0] off;
    if (span_shadow == 0) return {$urandom, $urandom};
    q = {12'd0, $urandom, 20'($urandom)};
    if (span_shadow > 12'd3840 && $urandom_range(0, 1) == 1)
      off = 64'($urandom_range(3840, int'(span_shadow) - 1));
    else
      off = 64'($urandom_range(0, (span_shadow > 12'd129) ? 128 : int'(span_shadow) - 1));
    return q * {52'd0, span_shadow} + off;
  endfunction

  function automatic bod_pkg::in_item_t make_write(logic [11:0] idx, logic [63:0] lo,
                                                   logic [63:0] hi);
    bod_pkg::in_item_t w;
    w.op = bod_pkg::OP_WRITE;
    w.slot = idx;
    w.data_lo = lo;
    w.data_hi = hi;
    w.band_lo = {$urandom, $urandom};
    w.band_hi = {$urandom, $urandom};
    return w;
  endfunction

  // Driver: sends requests in bursts with random gaps. The predictor runs at
  // acceptance, so expectations follow the exact order the block takes them.
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_request(in_item);
        void'(pending_requests.pop_front());
      end
      if (in_valid && !(in_ready)) begin
        // Hold the request steady until it is taken.
      end else if (pending_requests.size() > 0 && !sender_paused) begin
        if (in_valid && in_ready && burst_left > 0) begin
          burst_left <= burst_left - 1;
          in_valid <= 1'b1;
          in_item <= pending_requests[0];
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else begin
          if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
          in_valid <= 1'b1;
          in_item <= pending_requests[0];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver. The stall pattern alternates between calm
  // stretches and choppy ones; a long hold-off can be requested from the
  // stimulus process and is counted up here.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          $error("unexpected result value_lo=%h value_hi=%h",
                 out_item.value_lo, out_item.value_hi);
          fail_count++;
        end else begin
          if (out_item.value_lo !== expected_values[0].value_lo) begin
            $error("value_lo expected %h got %h", expected_values[0].value_lo,
                   out_item.value_lo);
            fail_count++;
          end
          if (out_item.value_hi !== expected_values[0].value_hi) begin
            $error("value_hi expected %h got %h", expected_values[0].value_hi,
                   out_item.value_hi);
            fail_count++;
          end
          void'(expected_values.pop_front());
        end
      end
      stall_phase <= (stall_phase + 1) % 512;
      if (hold_receiver) begin
        hold_cycles <= hold_cycles + 1;
        out_ready <= 1'b0;
      end else if (stall_phase < 200) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL band_okvs_decoder_top");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_requests.size() > 0 || in_valid || expected_values.size() > 0)
      @(posedge clk);
    // A trailing write can still be in flight after the last result.
    repeat (QUERY_CYCLES) @(posedge clk);
  endtask

  task automatic write_span(logic [bod_pkg::SPAN_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    span_shadow = value;
  endtask

  // Random phase: mostly queries with random rows; a fraction rewrites slots.
  task automatic random_phase(int count);
    logic [63:0] row_lo;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        pending_requests.push_back(make_write(12'($urandom), {$urandom, $urandom},
                                              {$urandom, $urandom}));
      end else begin
        // Wait until no more than two requests are pending so the predictor's view of
        // written slots is nearly current when the row is chosen.
        while (pending_requests.size() > 2) @(posedge clk);
        row_lo = pick_row();
        if (!low_half_safe(row_lo)) row_lo = 64'd0;
        pending_requests.push_back(make_query(row_lo, {$urandom, $urandom}));
      end
    end
  endtask

  initial begin
    span_shadow = bod_pkg::SPAN_RESET;
    for (int i = 0; i < bod_pkg::SLOTS_DEF; i++) begin
      slot_mirror[i] = '0;
      slot_written[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Extremes of data and slot index, then queries at the
    // edges of the band and of the table.
    pending_requests.push_back(make_write(12'd0, '1, '1));
    pending_requests.push_back(make_write(12'd4095, '0, '1));
    pending_requests.push_back(make_write(12'd1, 64'h0123456789abcdef, '0));
    pending_requests.push_back(make_write(12'd127, 64'h5555, 64'haaaa));
    wait_idle();
    // Fill the 512 slots from 3840 up through the end of the table and on to
    // slot 255; every query below keeps its band inside this block.
    for (int i = 0; i < 512; i++)
      pending_requests.push_back(make_write(12'(i + 3840), {$urandom, $urandom},
                                            {$urandom, $urandom}));
    wait_idle();
    pending_requests.push_back(make_query(64'd0, 64'd0));
    pending_requests.push_back(make_query(64'hffff_ffff_ffff_fe00, '1));
    pending_requests.push_back(make_query(64'd3967, 64'h8000_0000_0000_0001));
    pending_requests.push_back(make_query(64'd3968, 64'd0));
    wait_idle();

    // Zero span puts the start at slot 0.
    write_span(12'd0);
    pending_requests.push_back(make_query('1, '1));
    pending_requests.push_back(make_query(64'h1234, 64'hffff));
    wait_idle();
    // Largest span: the first band wraps past the end of the table.
    write_span(12'hfff);
    pending_requests.push_back(make_query(64'hffe, '1));
    pending_requests.push_back(make_query('1, '1));
    wait_idle();
    write_span(12'd1);
    pending_requests.push_back(make_query('1, 64'd5));
    wait_idle();

    // Long receiver hold-off while the sender keeps going, so the block's
    // queue fills and in_ready drops.
    write_span(12'd3968);
    hold_receiver = 1'b1;
    for (int i = 0; i < 6; i++)
      pending_requests.push_back(make_query(pick_row(), {$urandom, $urandom}));
    while (hold_cycles < 1500) @(posedge clk);
    hold_receiver = 1'b0;
    wait_idle();

    // Random phases over several span settings, extremes among them.
    write_span(12'd3968);
    random_phase(80);
    // Sender pause until every expected result has come.
    sender_paused = 1'b1;
    while (expected_values.size() > 0) @(posedge clk);
    sender_paused = 1'b0;
    wait_idle();
    write_span(12'd1);
    random_phase(40);
    wait_idle();
    write_span(12'd9);
    random_phase(50);
    wait_idle();
    write_span(12'($urandom_range(1, 3968)));
    random_phase(40);
    wait_idle();
    write_span(12'hfff);
    random_phase(30);
    wait_idle();
    write_span(12'd0);
    random_phase(30);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_values.size() == 0) begin
      $display("PASS band_okvs_decoder_top");
    end else begin
      if (expected_values.size() > 0)
        $error("%0d results never arrived", expected_values.size());
      $display("FAIL band_okvs_decoder_top");
    end
    $finish;
  end

endmodule
